### rtl/core/trw_pkg.sv
// shared types and command codes for the trace ring window snapshot block
// no dependencies
package trw_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_SNAP  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] event_time;
		logic [63:0] event_data;
		logic [63:0] window_start;
		logic [63:0] window_end;
	} in_item_t;

	typedef struct packed {
		logic [63:0] rec_time;
		logic [63:0] rec_data;
		logic        none_found;
		logic        final_item;
	} out_item_t;

	typedef struct packed {
		logic push;
		logic clear;
		logic snap;
		logic pass;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic pass_done;
		logic out_free;
		logic last;
		logic empty;
	} stat_t;

endpackage

### rtl/core/trw_if.sv
// valid/ready channel interfaces for requests and emitted records
// depends on trw_pkg
interface trw_in_if;
	logic             valid;
	logic             ready;
	trw_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trw_out_if;
	logic              valid;
	logic              ready;
	trw_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/trw_ctrl.sv
// controller: decodes requests and sequences scan passes and record emission
// depends on trw_pkg
module trw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      in_cmd,
	output logic            in_ready,
	input  trw_pkg::stat_t  st,
	output trw_pkg::ctl_t   ctl
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.push  = (in_cmd == trw_pkg::CMD_PUSH);
					ctl.clear = (in_cmd == trw_pkg::CMD_CLEAR);
					ctl.snap  = (in_cmd == trw_pkg::CMD_SNAP);
				end
			end
			S_SCAN: ;
			S_EMIT: ctl.emit = st.out_free;
			default: ;
		endcase
		if (state_q == S_EMIT && st.out_free && !(st.last || st.empty))
			ctl.pass = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid && in_cmd == trw_pkg::CMD_SNAP) state_q <= S_SCAN;
				S_SCAN: if (st.pass_done) state_q <= S_EMIT;
				S_EMIT: begin
					if (st.out_free)
						state_q <= (st.last || st.empty) ? S_IDLE : S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/trw_dp.sv
// datapath: record memory, pointers, min-key scan and output register
// depends on trw_pkg
module trw_dp #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  trw_pkg::in_item_t  req,
	input  trw_pkg::ctl_t      ctl,
	output trw_pkg::stat_t     st,
	output trw_pkg::out_item_t out_data,
	output logic               out_valid,
	input  logic               out_ready
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

	logic [63:0] stamp_mem [CAPACITY];
	logic [63:0] data_mem [CAPACITY];

	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;
	logic [63:0]   lo_q, hi_q;
	logic [CW-1:0] k_q;
	logic          issuing_q;
	logic          busy_q;
	logic          vld_s1;
	logic [AW-1:0] age_s1;
	logic [63:0]   t_s1, d_s1;
	logic [63:0]   best_t_q, best_d_q, last_t_q;
	logic [AW-1:0] best_age_q, last_age_q;
	logic          have_best_q, have_last_q;
	logic [CW-1:0] cnt_q, emitted_q;
	logic          out_valid_q;
	trw_pkg::out_item_t out_q;

	logic [CW:0]   idx_sum;
	logic [AW-1:0] rd_idx;
	logic          in_win, gt_last, lt_best, take;

	always_comb begin
		idx_sum = (CW + 1)'(wp_q) + CAP_W - (CW + 1)'(1) - (CW + 1)'(k_q);
		if (idx_sum >= CAP_W)
			idx_sum = idx_sum - CAP_W;
		rd_idx = idx_sum[AW-1:0];
	end

	assign in_win  = (t_s1 >= lo_q) && (t_s1 <= hi_q);
	assign gt_last = !have_last_q || (t_s1 > last_t_q) ||
		((t_s1 == last_t_q) && (age_s1 > last_age_q));
	assign lt_best = !have_best_q || (t_s1 < best_t_q) ||
		((t_s1 == best_t_q) && (age_s1 < best_age_q));
	assign take = vld_s1 && in_win && gt_last && lt_best;

	assign st.pass_done = busy_q && !issuing_q && !vld_s1;
	assign st.out_free  = !out_valid_q;
	assign st.last      = (emitted_q + CW'(1)) == cnt_q;
	assign st.empty     = (cnt_q == '0);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stamp_mem[wp_q] <= req.event_time;
			data_mem[wp_q]  <= req.event_data;
		end
		t_s1 <= stamp_mem[rd_idx];
		d_s1 <= data_mem[rd_idx];
		age_s1 <= k_q[AW-1:0];
		if (ctl.snap) begin
			lo_q <= req.window_start;
			hi_q <= req.window_end;
		end
		if (take) begin
			best_t_q   <= t_s1;
			best_d_q   <= d_s1;
			best_age_q <= age_s1;
		end
		if (ctl.emit) begin
			last_t_q   <= best_t_q;
			last_age_q <= best_age_q;
			if (cnt_q == '0) begin
				out_q <= '{rec_time: 64'd0, rec_data: 64'd0, none_found: 1'b1,
					final_item: 1'b1};
			end else begin
				out_q <= '{rec_time: best_t_q, rec_data: best_d_q, none_found: 1'b0,
					final_item: st.last};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			issuing_q   <= 1'b0;
			busy_q      <= 1'b0;
			vld_s1      <= 1'b0;
			have_best_q <= 1'b0;
			have_last_q <= 1'b0;
			cnt_q       <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= issuing_q;
			if (ctl.push) begin
				wp_q <= (32'(wp_q) + 1 >= CAPACITY) ? '0 : wp_q + AW'(1);
				if (fill_q != CW'(CAPACITY))
					fill_q <= fill_q + CW'(1);
			end
			if (ctl.clear) begin
				wp_q   <= '0;
				fill_q <= '0;
			end
			if (issuing_q) begin
				k_q <= k_q + CW'(1);
				if (k_q + CW'(1) == fill_q)
					issuing_q <= 1'b0;
			end
			if (take)
				have_best_q <= 1'b1;
			if (vld_s1 && in_win && !have_last_q)
				cnt_q <= cnt_q + CW'(1);
			if (ctl.snap) begin
				have_last_q <= 1'b0;
				cnt_q       <= '0;
				emitted_q   <= '0;
			end
			if (ctl.snap || ctl.pass) begin
				k_q         <= '0;
				issuing_q   <= (fill_q != '0);
				busy_q      <= 1'b1;
				have_best_q <= 1'b0;
			end
			if (ctl.emit) begin
				have_last_q <= 1'b1;
				emitted_q   <= emitted_q + CW'(1);
				out_valid_q <= 1'b1;
				if (!ctl.pass)
					busy_q <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/trace_ring_window_snapshot.sv
// top level: overwriting trace ring with windowed, time-sorted snapshot
// depends on trw_pkg, trw_if, trw_ctrl, trw_dp
//
//  channel  dir  payload                                          transfer
//  req      in   cmd, event_time, event_data, window_start/end    valid & ready
//  rec      out  rec_time, rec_data, none_found, final_item       valid & ready
//
// push and clear requests are taken back to back
// a snapshot with n > 0 stored and m matching records runs max(m,1) passes:
// each pass is one scan over all n stored records followed by one emit step
// a snapshot of an empty ring emits a single none_found record
// reset clears pointer, fill count and control; the record memory is not cleared
// requests are held off while a snapshot runs or waits on a stalled rec channel
module trace_ring_window_snapshot #(
	parameter int CAPACITY = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	trw_in_if.sink    req,
	trw_out_if.source rec
);

	trw_pkg::ctl_t  ctl;
	trw_pkg::stat_t st;

	trw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (req.data.cmd),
		.in_ready (req.ready),
		.st       (st),
		.ctl      (ctl)
	);

	trw_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.data),
		.ctl       (ctl),
		.st        (st),
		.out_data  (rec.data),
		.out_valid (rec.valid),
		.out_ready (rec.ready)
	);

endmodule

### tb/trw_tb_if.sv
// testbench-side note: channel interfaces come from the rtl file trw_if.sv
// this file holds the checker's record type for its ring model
package trw_tb_pkg;
	typedef struct packed {
		logic [63:0] t;
		logic [63:0] d;
	} ring_rec_t;
endpackage

### tb/trw_checker.sv
// checker: watches req and rec transfers, predicts snapshot output, compares
// depends on trw_pkg, trw_tb_pkg, trw_if
module trw_checker #(
	parameter int CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	trw_in_if    req,
	trw_out_if   rec,
	output int   fail_count,
	output int   pending
);

	trw_tb_pkg::ring_rec_t ring [CAPACITY];
	int unsigned           wr_ptr;
	int unsigned           fill;
	trw_pkg::out_item_t    snap_q [$];

	assign pending = snap_q.size();

	task automatic predict_req(input trw_pkg::in_item_t it);
		trw_tb_pkg::ring_rec_t sel [$];
		trw_tb_pkg::ring_rec_t r;
		trw_pkg::out_item_t    o;
		int                    j;
		case (trw_pkg::cmd_t'(it.cmd))
			trw_pkg::CMD_PUSH: begin
				ring[wr_ptr] = '{it.event_time, it.event_data};
				wr_ptr = (wr_ptr + 1 >= CAPACITY) ? 0 : wr_ptr + 1;
				if (fill < CAPACITY) fill++;
			end
			trw_pkg::CMD_CLEAR: begin
				wr_ptr = 0;
				fill = 0;
			end
			trw_pkg::CMD_SNAP: begin
				for (int k = 1; k <= fill; k++) begin
					r = ring[(wr_ptr + CAPACITY - k) % CAPACITY];
					if (r.t >= it.window_start && r.t <= it.window_end) begin
						j = sel.size();
						while (j > 0 && sel[j-1].t > r.t) j--;
						sel.insert(j, r);
					end
				end
				if (sel.size() == 0) begin
					o = '{64'd0, 64'd0, 1'b1, 1'b1};
					snap_q = {snap_q, o};
				end else begin
					foreach (sel[k]) begin
						o = '{sel[k].t, sel[k].d, 1'b0, k == sel.size() - 1};
						snap_q = {snap_q, o};
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		trw_pkg::out_item_t e;
		if (!arst_n) begin
			wr_ptr = 0;
			fill = 0;
			fail_count = 0;
		end else begin
			if (rec.valid && rec.ready) begin
				if (snap_q.size() == 0) begin
					$error("unexpected rec transfer t=%h", rec.data.rec_time);
					fail_count++;
				end else begin
					e = snap_q.pop_front();
					if (e.rec_time !== rec.data.rec_time) begin
						$error("rec_time exp %h got %h", e.rec_time, rec.data.rec_time);
						fail_count++;
					end
					if (e.rec_data !== rec.data.rec_data) begin
						$error("rec_data exp %h got %h", e.rec_data, rec.data.rec_data);
						fail_count++;
					end
					if (e.none_found !== rec.data.none_found) begin
						$error("none_found exp %b got %b", e.none_found, rec.data.none_found);
						fail_count++;
					end
					if (e.final_item !== rec.data.final_item) begin
						$error("final_item exp %b got %b", e.final_item, rec.data.final_item);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				predict_req(req.data);
		end
	end
endmodule

### tb/tb_top.sv
// testbench top: clock, reset, request stimulus, rec back-pressure and verdict
// depends on trw_pkg, trw_if, trw_checker and the trace_ring_window_snapshot rtl
module tb_top;

	localparam int CAP = 32;
	localparam int CYCLE_LIMIT = 3000000;

	logic      clk = 0;
	logic      arst_n = 0;
	int        fails;
	int        waiting;
	int        cycles = 0;
	bit        calm = 0;
	bit        hold_off = 0;
	logic [63:0] time_base = 0;

	trw_in_if  req ();
	trw_out_if rec ();

	trace_ring_window_snapshot #(.CAPACITY(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rec(rec)
	);

	trw_checker #(.CAPACITY(CAP)) chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rec(rec),
		.fail_count(fails), .pending(waiting)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (!arst_n || hold_off) rec.ready <= 0;
		else rec.ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input trw_pkg::cmd_t c, input logic [63:0] et,
			input logic [63:0] ed, input logic [63:0] ws, input logic [63:0] we);
		while (!calm && $urandom_range(99) < 22) begin
			req.valid = 0;
			@(negedge clk);
		end
		req.valid = 1;
		req.data = '{c, et, ed, ws, we};
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic push_r(input logic [63:0] et);
		send(trw_pkg::CMD_PUSH, et, rnd64(), rnd64(), rnd64());
	endtask

	task automatic snap_r(input logic [63:0] ws, input logic [63:0] we);
		send(trw_pkg::CMD_SNAP, rnd64(), rnd64(), ws, we);
	endtask

	function automatic logic [63:0] near_time();
		return time_base + $urandom_range(40);
	endfunction

	initial begin
		logic [63:0] a, b;
		req.valid = 0;
		req.data = '0;
		@(posedge arst_n);
		@(negedge clk);
		// directed
		snap_r(64'd0, '1);
		push_r(64'd0);
		push_r('1);
		push_r(64'd5);
		push_r(64'd5);
		send(trw_pkg::CMD_PUSH, 64'd3, '1, '1, '1);
		snap_r(64'd0, '1);
		snap_r(64'd5, 64'd5);
		snap_r(64'd9, 64'd4);
		send(trw_pkg::CMD_NOP, rnd64(), rnd64(), 64'd0, '1);
		snap_r('1, '1);
		send(trw_pkg::CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
		snap_r(64'd0, '1);
		for (int i = 0; i < 36; i++) push_r(64'd100 - i % 7);
		snap_r(64'd0, '1);
		// hold rec off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				snap_r(64'd0, '1);
				push_r(64'd1);
				snap_r(64'd0, 64'd50);
			end
		join
		// random
		for (int i = 0; i < 400; i++) begin
			int r;
			calm = (i >= 150 && i < 220);
			r = $urandom_range(99);
			if (r < 70) begin
				push_r($urandom_range(3) == 0 ? rnd64() : near_time());
			end else if (r < 88) begin
				a = time_base + $urandom_range(20);
				b = a + $urandom_range(30);
				if ($urandom_range(9) == 0) snap_r(rnd64(), rnd64());
				else if ($urandom_range(9) == 0) snap_r(b, a);
				else snap_r(a, b);
			end else if (r < 92) begin
				send(trw_pkg::CMD_CLEAR, rnd64(), rnd64(), rnd64(), rnd64());
			end else if (r < 95) begin
				send(trw_pkg::CMD_NOP, rnd64(), rnd64(), rnd64(), rnd64());
			end else begin
				time_base = rnd64();
			end
		end
		calm = 0;
		while (waiting != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (fails == 0 && waiting == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
